// ----- rtl/core/mips_subset_core_unit_defines.svh -----
// ---------------------------------------------------------------------------
// MIPS subset core assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef MIPS_SUBSET_CORE_UNIT_DEFINES_SVH
`define MIPS_SUBSET_CORE_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define MSC_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("msc assertion failed");

// next-cycle implication
`define MSC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("msc assertion failed");

`else

`define MSC_ASSERT_IMPLY(label, ante, cons)
`define MSC_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ----- rtl/core/msc_pkg.sv -----
// ---------------------------------------------------------------------------
// MIPS subset core package
// Payload types, decode constants and stage records shared by the core.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package msc_pkg;

   // item selector
   localparam logic [1:0] FUNC_EXEC      = 2'd0;
   localparam logic [1:0] FUNC_PRELOAD   = 2'd1;
   localparam logic [1:0] FUNC_READ_BYTE = 2'd2;
   localparam logic [1:0] FUNC_READ_REG  = 2'd3;

   // instruction decode
   localparam logic [5:0]  OP_RTYPE  = 6'h00;
   localparam logic [5:0]  OP_LW     = 6'h23;
   localparam logic [5:0]  OP_SW     = 6'h2B;
   localparam logic [5:0]  OP_BNE    = 6'h05;
   localparam logic [5:0]  FN_ADDU   = 6'h21;
   localparam logic [5:0]  FN_SUBU   = 6'h23;
   localparam logic [31:0] HALT_WORD = 32'hFFFF_FFFF;

   // data access kind
   localparam logic [1:0] MEM_NONE  = 2'd0;
   localparam logic [1:0] MEM_LOAD  = 2'd1;
   localparam logic [1:0] MEM_STORE = 2'd2;

   localparam logic [4:0] REG_ZERO = 5'd0;

   typedef struct packed {
      logic [1:0]  func;
      logic [31:0] instr_word;
      logic [9:0]  access_index;
      logic [7:0]  preload_byte;
   } req_payload_type;

   typedef struct packed {
      logic [31:0] next_pc;
      logic        halted;
      logic        branch_taken;
      logic        reg_written;
      logic [4:0]  dest_reg;
      logic [31:0] dest_value;
      logic [1:0]  mem_op;
      logic [9:0]  mem_addr;
      logic [31:0] read_value;
   } rsp_payload_type;

   // register bypass from the data stage
   typedef struct packed {
      logic        valid;
      logic [4:0]  dest;
      logic [31:0] value;
   } fwd_type;

   // execute stage record, carried into the data stage
   typedef struct packed {
      logic [31:0]     pc_next;
      logic            halt_next;
      logic            is_load;
      logic            is_byte_read;
      logic [1:0]      lane_off;
      rsp_payload_type rsp;
   } exec_type;

endpackage

// ----- rtl/core/msc_regfile.sv -----
// ---------------------------------------------------------------------------
// MIPS subset core register file
// 32 x 32 with two registered read ports, one write port, write-first
// reads and per-entry valid bits; an entry never written reads as zero.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module msc_regfile (
   input  logic        clock,
   input  logic        reset,
   input  logic        we,
   input  logic [4:0]  waddr,
   input  logic [31:0] wdata,
   input  logic        re,
   input  logic [4:0]  raddr_a,
   input  logic [4:0]  raddr_b,
   output logic [31:0] rdata_a,
   output logic [31:0] rdata_b
);

   logic [31:0] regs_ff [32];
   logic [31:0] valid_ff;
   logic [31:0] rd_a_ff;
   logic [31:0] rd_b_ff;
   logic        rv_a_ff;
   logic        rv_b_ff;
   logic        hit_a;
   logic        hit_b;

   assign hit_a = we && (waddr == raddr_a);
   assign hit_b = we && (waddr == raddr_b);

   always_ff @(posedge clock) begin
      if (we) begin
         regs_ff[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (we) begin
         valid_ff[waddr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rd_a_ff <= hit_a ? wdata : regs_ff[raddr_a];
         rd_b_ff <= hit_b ? wdata : regs_ff[raddr_b];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rv_a_ff <= 1'b0;
         rv_b_ff <= 1'b0;
      end else if (re) begin
         rv_a_ff <= valid_ff[raddr_a] | hit_a;
         rv_b_ff <= valid_ff[raddr_b] | hit_b;
      end
   end

   assign rdata_a = rv_a_ff ? rd_a_ff : 32'd0;
   assign rdata_b = rv_b_ff ? rd_b_ff : 32'd0;

endmodule

// ----- rtl/core/msc_lane_ram.sv -----
// ---------------------------------------------------------------------------
// MIPS subset core data lane
// One byte lane of the data store: single address, registered read.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module msc_lane_ram #(
   parameter int ROW_BITS = 8
) (
   input  logic                clock,
   input  logic                we,
   input  logic                re,
   input  logic [ROW_BITS-1:0] addr,
   input  logic [7:0]          wdata,
   output logic [7:0]          rdata
);

   logic [7:0] mem_ff [2**ROW_BITS];
   logic [7:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- rtl/core/msc_exec.sv -----
// ---------------------------------------------------------------------------
// MIPS subset core execute stage
// Decode, operand bypass, ALU, branch, effective address and lane steering
// for the item in the execute stage.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module msc_exec #(
   parameter int ADDR_BITS = 10
) (
   input  msc_pkg::req_payload_type        req,
   input  logic [31:0]                     pc,
   input  logic                            halted,
   input  logic [31:0]                     rs_raw,
   input  logic [31:0]                     rt_raw,
   input  msc_pkg::fwd_type                fwd,
   output msc_pkg::exec_type               res,
   output logic [3:0]                      lane_we,
   output logic [3:0][ADDR_BITS-3:0]       lane_row,
   output logic [3:0][7:0]                 lane_wdata
);

   localparam int ROW_BITS = ADDR_BITS - 2;

   logic [4:0]            rs_sel;
   logic [4:0]            rt_sel;
   logic [4:0]            rd_sel;
   logic [5:0]            opcode;
   logic [5:0]            funct;
   logic [31:0]           imm_ext;
   logic [31:0]           op_a;
   logic [31:0]           op_b;
   logic [31:0]           pc_plus4;
   logic [31:0]           ea_sum;
   logic [ADDR_BITS+9:0]  idx_wide;
   logic [ADDR_BITS+9:0]  ea_wide;
   logic [ADDR_BITS-1:0]  addr;
   logic [1:0]            off;
   logic [ROW_BITS-1:0]   row_base;
   logic [1:0]            byte_sel;
   logic [1:0]            lane_id;

   assign opcode  = req.instr_word[31:26];
   assign rt_sel  = req.instr_word[20:16];
   assign rd_sel  = req.instr_word[15:11];
   assign funct   = req.instr_word[5:0];
   assign imm_ext = {{16{req.instr_word[15]}}, req.instr_word[15:0]};
   assign rs_sel  = (req.func == msc_pkg::FUNC_READ_REG) ? req.access_index[4:0]
                                                         : req.instr_word[25:21];

   // the data-stage item has not written back yet
   assign op_a = (fwd.valid && fwd.dest == rs_sel) ? fwd.value : rs_raw;
   assign op_b = (fwd.valid && fwd.dest == rt_sel) ? fwd.value : rt_raw;

   assign pc_plus4 = pc + 32'd4;
   assign ea_sum   = op_a + imm_ext;
   assign idx_wide = {{ADDR_BITS{1'b0}}, req.access_index};
   assign ea_wide  = {{10{1'b0}}, ea_sum[ADDR_BITS-1:0]};

   always_comb begin
      res                  = '0;
      res.pc_next          = pc;
      res.halt_next        = halted;
      addr                 = idx_wide[ADDR_BITS-1:0];
      lane_we              = '0;
      case (req.func)
         msc_pkg::FUNC_PRELOAD: begin
            lane_we[addr[1:0]] = 1'b1;
         end
         msc_pkg::FUNC_READ_BYTE: begin
            res.is_byte_read = 1'b1;
         end
         msc_pkg::FUNC_READ_REG: begin
            res.rsp.read_value = op_a;
         end
         msc_pkg::FUNC_EXEC: begin
            if (!halted) begin
               if (req.instr_word == msc_pkg::HALT_WORD) begin
                  res.halt_next = 1'b1;
               end else begin
                  res.pc_next = pc_plus4;
                  case (opcode)
                     msc_pkg::OP_RTYPE: begin
                        if ((funct == msc_pkg::FN_ADDU || funct == msc_pkg::FN_SUBU)
                            && rd_sel != msc_pkg::REG_ZERO) begin
                           res.rsp.reg_written = 1'b1;
                           res.rsp.dest_reg    = rd_sel;
                           res.rsp.dest_value  = (funct == msc_pkg::FN_ADDU) ? op_a + op_b
                                                                            : op_a - op_b;
                        end
                     end
                     msc_pkg::OP_LW: begin
                        addr             = ea_sum[ADDR_BITS-1:0];
                        res.rsp.mem_op   = msc_pkg::MEM_LOAD;
                        res.rsp.mem_addr = ea_wide[9:0];
                        res.is_load      = 1'b1;
                        if (rt_sel != msc_pkg::REG_ZERO) begin
                           res.rsp.reg_written = 1'b1;
                           res.rsp.dest_reg    = rt_sel;
                        end
                     end
                     msc_pkg::OP_SW: begin
                        addr             = ea_sum[ADDR_BITS-1:0];
                        res.rsp.mem_op   = msc_pkg::MEM_STORE;
                        res.rsp.mem_addr = ea_wide[9:0];
                        lane_we          = 4'hF;
                     end
                     msc_pkg::OP_BNE: begin
                        if (op_a != op_b) begin
                           res.rsp.branch_taken = 1'b1;
                           res.pc_next = pc_plus4 + {imm_ext[29:0], 2'b00};
                        end
                     end
                     default: begin
                        // unknown opcode: PC advance only
                     end
                  endcase
               end
            end
         end
         default: begin
         end
      endcase
      res.rsp.next_pc = res.pc_next;
      res.rsp.halted  = res.halt_next;
      res.lane_off    = addr[1:0];
   end

   assign off      = addr[1:0];
   assign row_base = addr[ADDR_BITS-1:2];

   // lanes below the start offset hold the bytes that spill into the next row
   always_comb begin
      lane_row   = '0;
      lane_wdata = '0;
      byte_sel   = '0;
      lane_id    = '0;
      for (int l = 0; l < 4; l++) begin
         lane_id     = 2'(l);
         lane_row[l] = row_base + ROW_BITS'(lane_id < off);
         byte_sel    = 2'(2'd3 - 2'(lane_id - off));
         if (req.func == msc_pkg::FUNC_PRELOAD) begin
            lane_wdata[l] = req.preload_byte;
         end else begin
            lane_wdata[l] = op_b[{byte_sel, 3'b000} +: 8];
         end
      end
   end

endmodule

// ----- rtl/core/mips_subset_core_unit.sv -----
// ---------------------------------------------------------------------------
// MIPS subset core
// In-order executor for addu, subu, lw, sw, bne and halt, with direct
// data-byte preload/read and register read items.
// ---------------------------------------------------------------------------
// Accepts one item per cycle while req_stall is low and returns one result
// item per item, in order; a result passes the execute stage, the data stage
// and the output register before it shows on rsp_valid. The rate is set by
// the single commit point in the execute stage: PC, halt flag and data-store
// writes update there at most once per cycle, as an item leaves it, and the
// data store is four byte-lane RAMs that each serve one row per cycle, so an
// unaligned word needs no second access. Load results reach the register file
// from the data stage and are bypassed to the next item. After reset the data
// store is cleared one row of four bytes per cycle, with req_stall held high.
// DATA_BYTES must be a power of two.
`timescale 1ns / 1ps
`include "mips_subset_core_unit_defines.svh"

module mips_subset_core_unit #(
   parameter int DATA_BYTES = 1024
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  msc_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output msc_pkg::rsp_payload_type rsp_payload
);

   localparam int ADDR_BITS = $clog2(DATA_BYTES);
   localparam int ROW_BITS  = ADDR_BITS - 2;

   // pipeline control
   logic out_free;
   logic s2_move;
   logic s2_free;
   logic s1_move;
   logic s1_free;
   logic req_accept;

   logic                     s1_valid_ff, s1_valid_in;
   msc_pkg::req_payload_type s1_ff;
   logic                     s2_valid_ff, s2_valid_in;
   msc_pkg::exec_type        s2_ff;
   logic                     out_valid_ff, out_valid_in;
   msc_pkg::rsp_payload_type out_ff;

   logic [31:0] pc_ff;
   logic        halt_ff;

   logic                clr_active_ff;
   logic [ROW_BITS-1:0] clr_row_ff;

   // register file
   logic        rf_we;
   logic [4:0]  rf_waddr;
   logic [31:0] rs_raw;
   logic [31:0] rt_raw;
   logic [4:0]  rf_raddr_a;

   // execute stage
   msc_pkg::exec_type              ex_res;
   msc_pkg::fwd_type               fwd;
   logic [3:0]                     ex_lane_we;
   logic [3:0][ROW_BITS-1:0]       ex_lane_row;
   logic [3:0][7:0]                ex_lane_wdata;

   // data lanes
   logic [3:0]               ram_we;
   logic [3:0][ROW_BITS-1:0] ram_addr;
   logic [3:0][7:0]          ram_wdata;
   logic [3:0][7:0]          ram_rdata;

   logic [31:0]              load_word;
   msc_pkg::rsp_payload_type rsp_fin;

   assign out_free   = !out_valid_ff || !rsp_stall;
   assign s2_move    = s2_valid_ff && out_free;
   assign s2_free    = !s2_valid_ff || out_free;
   assign s1_move    = s1_valid_ff && s2_free;
   assign s1_free    = !s1_valid_ff || s2_free;
   assign req_stall  = clr_active_ff || !s1_free;
   assign req_accept = req_valid && !req_stall;

   assign s1_valid_in  = req_accept || (s1_valid_ff && !s2_free);
   assign s2_valid_in  = s1_move || (s2_valid_ff && !out_free);
   assign out_valid_in = s2_move || (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         pc_ff         <= 32'd0;
         halt_ff       <= 1'b0;
         clr_active_ff <= 1'b1;
         clr_row_ff    <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         out_valid_ff <= out_valid_in;
         if (s1_move) begin
            pc_ff   <= ex_res.pc_next;
            halt_ff <= ex_res.halt_next;
         end
         if (clr_active_ff) begin
            clr_row_ff <= clr_row_ff + ROW_BITS'(1);
            if (clr_row_ff == {ROW_BITS{1'b1}}) begin
               clr_active_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_ff <= req_payload;
      end
      if (s1_move) begin
         s2_ff <= ex_res;
      end
      if (s2_move) begin
         out_ff <= rsp_fin;
      end
   end

   // operands are read as the item is accepted
   assign rf_raddr_a = (req_payload.func == msc_pkg::FUNC_READ_REG)
                       ? req_payload.access_index[4:0] : req_payload.instr_word[25:21];
   assign rf_we      = s2_move && rsp_fin.reg_written;
   assign rf_waddr   = rsp_fin.dest_reg;

   msc_regfile u_regfile (
      .clock   (clock),
      .reset   (reset),
      .we      (rf_we),
      .waddr   (rf_waddr),
      .wdata   (rsp_fin.dest_value),
      .re      (req_accept),
      .raddr_a (rf_raddr_a),
      .raddr_b (req_payload.instr_word[20:16]),
      .rdata_a (rs_raw),
      .rdata_b (rt_raw)
   );

   assign fwd.valid = s2_valid_ff && rsp_fin.reg_written;
   assign fwd.dest  = rsp_fin.dest_reg;
   assign fwd.value = rsp_fin.dest_value;

   msc_exec #(
      .ADDR_BITS (ADDR_BITS)
   ) u_exec (
      .req        (s1_ff),
      .pc         (pc_ff),
      .halted     (halt_ff),
      .rs_raw     (rs_raw),
      .rt_raw     (rt_raw),
      .fwd        (fwd),
      .res        (ex_res),
      .lane_we    (ex_lane_we),
      .lane_row   (ex_lane_row),
      .lane_wdata (ex_lane_wdata)
   );

   for (genvar l = 0; l < 4; l++) begin : g_lane
      assign ram_we[l]    = clr_active_ff || (s1_move && ex_lane_we[l]);
      assign ram_addr[l]  = clr_active_ff ? clr_row_ff : ex_lane_row[l];
      assign ram_wdata[l] = clr_active_ff ? 8'd0 : ex_lane_wdata[l];

      msc_lane_ram #(
         .ROW_BITS (ROW_BITS)
      ) u_lane (
         .clock (clock),
         .we    (ram_we[l]),
         .re    (s1_move),
         .addr  (ram_addr[l]),
         .wdata (ram_wdata[l]),
         .rdata (ram_rdata[l])
      );
   end

   // big-endian: byte 0 of the word sits in the lane of the start offset
   always_comb begin
      load_word = '0;
      for (int i = 0; i < 4; i++) begin
         load_word[(3 - i) * 8 +: 8] = ram_rdata[2'(s2_ff.lane_off + 2'(i))];
      end
   end

   always_comb begin
      rsp_fin = s2_ff.rsp;
      if (s2_ff.is_load && s2_ff.rsp.reg_written) begin
         rsp_fin.dest_value = load_word;
      end
      if (s2_ff.is_byte_read) begin
         rsp_fin.read_value = {24'd0, ram_rdata[s2_ff.lane_off]};
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

   `MSC_ASSERT_IMPLY(a_rf_no_r0_write, rf_we, rf_waddr != msc_pkg::REG_ZERO)
   `MSC_ASSERT_IMPLY(a_clear_idle, clr_active_ff, !s1_valid_ff && !s2_valid_ff && !out_valid_ff)
   `MSC_ASSERT_NEXT(a_pc_only_on_commit, !s1_move, $stable(pc_ff))
   `MSC_ASSERT_NEXT(a_halt_sticky, halt_ff, halt_ff)

endmodule
